/* design/fsp_pkg.sv */
package fsp_pkg;

  localparam int unsigned GRID_SIZE_DEF = 256;
  localparam int unsigned FIFO_DEPTH    = 2;
  localparam logic [5:0]  HOT_HEAT      = 6'd36;

  typedef struct packed {
    logic [7:0] src_x;
    logic [8:0] src_y;
    logic [1:0] decay;
    logic       drift;
  } fsp_in_t;

  typedef struct packed {
    logic [7:0] dst_x;
    logic [7:0] dst_y;
    logic [5:0] heat;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } fsp_out_t;

  // classified request as it waits between front and back
  typedef struct packed {
    logic [7:0] dst_x;
    logic [7:0] dst_y;
    logic [1:0] decay;
    logic       hot;
  } fsp_job_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } fsp_rgb_t;

  function automatic fsp_rgb_t palette_lookup(logic [5:0] idx);
    fsp_rgb_t c;
    case (idx)
      6'd0:  c = '{8'd7,   8'd7,   8'd7};
      6'd1:  c = '{8'd31,  8'd7,   8'd7};
      6'd2:  c = '{8'd47,  8'd15,  8'd7};
      6'd3:  c = '{8'd71,  8'd15,  8'd7};
      6'd4:  c = '{8'd87,  8'd23,  8'd7};
      6'd5:  c = '{8'd103, 8'd31,  8'd7};
      6'd6:  c = '{8'd119, 8'd31,  8'd7};
      6'd7:  c = '{8'd143, 8'd39,  8'd7};
      6'd8:  c = '{8'd159, 8'd47,  8'd7};
      6'd9:  c = '{8'd175, 8'd63,  8'd7};
      6'd10: c = '{8'd191, 8'd71,  8'd7};
      6'd11: c = '{8'd199, 8'd71,  8'd7};
      6'd12: c = '{8'd223, 8'd79,  8'd7};
      6'd13: c = '{8'd223, 8'd87,  8'd7};
      6'd14: c = '{8'd223, 8'd87,  8'd7};
      6'd15: c = '{8'd215, 8'd95,  8'd7};
      6'd16: c = '{8'd215, 8'd95,  8'd7};
      6'd17: c = '{8'd215, 8'd103, 8'd15};
      6'd18: c = '{8'd207, 8'd111, 8'd15};
      6'd19: c = '{8'd207, 8'd119, 8'd15};
      6'd20: c = '{8'd207, 8'd127, 8'd15};
      6'd21: c = '{8'd207, 8'd135, 8'd23};
      6'd22: c = '{8'd199, 8'd135, 8'd23};
      6'd23: c = '{8'd199, 8'd143, 8'd23};
      6'd24: c = '{8'd199, 8'd151, 8'd31};
      6'd25: c = '{8'd191, 8'd159, 8'd31};
      6'd26: c = '{8'd191, 8'd159, 8'd31};
      6'd27: c = '{8'd191, 8'd167, 8'd39};
      6'd28: c = '{8'd191, 8'd167, 8'd39};
      6'd29: c = '{8'd191, 8'd175, 8'd47};
      6'd30: c = '{8'd183, 8'd175, 8'd47};
      6'd31: c = '{8'd183, 8'd183, 8'd47};
      6'd32: c = '{8'd183, 8'd183, 8'd55};
      6'd33: c = '{8'd207, 8'd207, 8'd111};
      6'd34: c = '{8'd223, 8'd223, 8'd159};
      6'd35: c = '{8'd239, 8'd239, 8'd199};
      6'd36: c = '{8'd255, 8'd255, 8'd255};
      default: c = '{8'd0, 8'd0, 8'd0};
    endcase
    return c;
  endfunction

endpackage

/* design/fsp_ram.sv */
module fsp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fsp_fifo.sv */
module fsp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i & ~full_o;
  assign pop_ok  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* design/fsp_front.sv */
module fsp_front import fsp_pkg::*; #(
  parameter int unsigned GridSize = GRID_SIZE_DEF
) (
  input  logic                                   push_i,
  input  fsp_in_t                                in_data_i,
  output logic                                   full_o,
  input  logic                                   clearing_i,
  input  logic                                   q_full_i,
  output logic                                   q_push_o,
  output fsp_job_t                               q_job_o,
  output logic [$clog2(GridSize*GridSize)-1:0]   q_src_addr_o,
  output logic [$clog2(GridSize*GridSize)-1:0]   q_dst_addr_o
);

  localparam int unsigned AW = $clog2(GridSize * GridSize);
  localparam logic [AW-1:0] AddrGrid = AW'(GridSize);

  logic [8:0] col_sum, col;
  logic [8:0] dst_row;
  logic       in_range;
  logic       accept;

  // drop rows 0 and above the hot row, and columns off the grid
  assign in_range = (in_data_i.src_y != '0) &&
                    (32'(in_data_i.src_y) <= GridSize) &&
                    (32'(in_data_i.src_x) < GridSize);

  assign col_sum = {1'b0, in_data_i.src_x} + 9'(in_data_i.drift);
  assign col     = (32'(col_sum) >= GridSize) ? '0 : col_sum;
  assign dst_row = in_data_i.src_y - 9'd1;

  assign q_src_addr_o = AW'(in_data_i.src_y) * AddrGrid + AW'(col);
  assign q_dst_addr_o = AW'(dst_row) * AddrGrid + AW'(in_data_i.src_x);

  assign q_job_o.dst_x = in_data_i.src_x;
  assign q_job_o.dst_y = dst_row[7:0];
  assign q_job_o.decay = in_data_i.decay;
  assign q_job_o.hot   = (32'(in_data_i.src_y) == GridSize);

  assign full_o   = q_full_i | clearing_i;
  assign accept   = push_i & ~full_o;
  assign q_push_o = accept & in_range;

endmodule

/* design/fsp_back.sv */
module fsp_back import fsp_pkg::*; #(
  parameter int unsigned GridSize = GRID_SIZE_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  output logic                                 clearing_o,
  input  logic                                 q_empty_i,
  input  fsp_job_t                             q_job_i,
  input  logic [$clog2(GridSize*GridSize)-1:0] q_src_addr_i,
  input  logic [$clog2(GridSize*GridSize)-1:0] q_dst_addr_i,
  output logic                                 q_pop_o,
  input  logic                                 out_full_i,
  output logic                                 out_push_o,
  output fsp_out_t                             out_data_o
);

  localparam int unsigned Depth = GridSize * GridSize;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  logic          clr_q, clr_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  logic          s2_valid_q, s2_valid_d;
  fsp_job_t      s2_job_q;
  logic [AW-1:0] s2_src_addr_q, s2_dst_addr_q;

  logic          fwd_valid_q, fwd_valid_d;
  logic [AW-1:0] fwd_addr_q;
  logic [5:0]    fwd_heat_q;

  logic          issue, s2_fire;
  logic          we;
  logic [AW-1:0] waddr;
  logic [5:0]    wdata, rdata;
  logic [5:0]    src_heat, src_clamp, new_heat;
  fsp_rgb_t      rgb;

  assign clearing_o = clr_q;
  assign s2_fire    = s2_valid_q & ~out_full_i;
  assign issue      = ~q_empty_i & ~clr_q & (~s2_valid_q | s2_fire);
  assign q_pop_o    = issue;

  fsp_ram #(
    .Width(6),
    .Depth(Depth)
  ) u_heat_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (issue),
    .raddr_i(q_src_addr_i),
    .rdata_o(rdata)
  );

  // a read issued alongside the previous write returns stale data
  always_comb begin
    if (s2_job_q.hot) begin
      src_heat = HOT_HEAT;
    end else if (fwd_valid_q && (fwd_addr_q == s2_src_addr_q)) begin
      src_heat = fwd_heat_q;
    end else begin
      src_heat = rdata;
    end
    src_clamp = (src_heat > HOT_HEAT) ? HOT_HEAT : src_heat;
    new_heat  = (src_clamp > 6'(s2_job_q.decay)) ? src_clamp - 6'(s2_job_q.decay) : '0;
    rgb       = palette_lookup(new_heat);
  end

  assign we    = clr_q | s2_fire;
  assign waddr = clr_q ? clr_addr_q : s2_dst_addr_q;
  assign wdata = clr_q ? '0 : new_heat;

  assign out_push_o       = s2_fire;
  assign out_data_o.dst_x = s2_job_q.dst_x;
  assign out_data_o.dst_y = s2_job_q.dst_y;
  assign out_data_o.heat  = new_heat;
  assign out_data_o.red   = (new_heat == '0) ? '0 : rgb.red;
  assign out_data_o.green = (new_heat == '0) ? '0 : rgb.green;
  assign out_data_o.blue  = (new_heat == '0) ? '0 : rgb.blue;

  always_comb begin
    clr_d       = clr_q;
    clr_addr_d  = clr_addr_q;
    s2_valid_d  = s2_valid_q;
    fwd_valid_d = fwd_valid_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == LastAddr) begin
        clr_d = 1'b0;
      end
    end
    if (issue) begin
      s2_valid_d = 1'b1;
    end else if (s2_fire) begin
      s2_valid_d = 1'b0;
    end
    if (s2_fire) begin
      fwd_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_addr_q  <= clr_addr_d;
      s2_valid_q  <= s2_valid_d;
      fwd_valid_q <= fwd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_job_q      <= q_job_i;
      s2_src_addr_q <= q_src_addr_i;
      s2_dst_addr_q <= q_dst_addr_i;
    end
    if (s2_fire) begin
      fwd_addr_q <= s2_dst_addr_q;
      fwd_heat_q <= new_heat;
    end
  end

  a_no_issue_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !issue && !s2_valid_q)
    else $error("request issued during clear pass");

  a_heat_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire |-> new_heat <= HOT_HEAT)
    else $error("heat above hot level");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && out_full_i |=> s2_valid_q && $stable(s2_dst_addr_q))
    else $error("stalled request lost");

  a_fwd_tracks_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire |=> fwd_valid_q && (fwd_addr_q == $past(s2_dst_addr_q)))
    else $error("forward register missed a write");

endmodule

/* design/fire_spread_pixel_update.sv */
// Fire spread pixel update.
// Input queue: drive in_data_i and raise push; the request is taken at a
// clock edge where push is high and full is low. Each request reads the
// heat at (src_x + drift, src_y), subtracts decay and writes the result to
// (src_x, src_y - 1). Requests for row 0, rows past the hot row or columns
// off the grid are taken and dropped with no result.
// Result queue: while empty is low, out_data_o holds the oldest result;
// raise pop to take it.
// Each request passes the request queue, a read stage and the result queue.
// Throughput: one request per cycle, set by the single heat RAM doing one
// read and one write per cycle (back-to-back hits on the same pixel are
// forwarded). A full result queue stalls the back end; the request queue
// then fills and full goes high.
// Reset: the heat RAM is zeroed by a clear pass over all GRID_SIZE * GRID_SIZE
// addresses (65536 at the default size); full stays high until it ends.
module fire_spread_pixel_update import fsp_pkg::*; #(
  parameter int unsigned GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  fsp_in_t  in_data_i,
  output logic     full,
  output logic     empty,
  input  logic     pop,
  output fsp_out_t out_data_o
);

  localparam int unsigned AW = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int unsigned QW = $bits(fsp_job_t) + 2 * AW;

  logic          clearing;
  logic          q_push, q_full, q_empty, q_pop;
  fsp_job_t      f_job, b_job;
  logic [AW-1:0] f_src_addr, f_dst_addr, b_src_addr, b_dst_addr;
  logic [QW-1:0] q_wdata, q_rdata;
  logic          out_push, out_full;
  fsp_out_t      out_wdata;

  fsp_front #(
    .GridSize(GRID_SIZE)
  ) u_front (
    .push_i      (push),
    .in_data_i   (in_data_i),
    .full_o      (full),
    .clearing_i  (clearing),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (f_job),
    .q_src_addr_o(f_src_addr),
    .q_dst_addr_o(f_dst_addr)
  );

  assign q_wdata = {f_job, f_src_addr, f_dst_addr};
  assign {b_job, b_src_addr, b_dst_addr} = q_rdata;

  fsp_fifo #(
    .Width(QW),
    .Depth(FIFO_DEPTH)
  ) u_req_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  fsp_back #(
    .GridSize(GRID_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clearing_o  (clearing),
    .q_empty_i   (q_empty),
    .q_job_i     (b_job),
    .q_src_addr_i(b_src_addr),
    .q_dst_addr_i(b_dst_addr),
    .q_pop_o     (q_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_data_o  (out_wdata)
  );

  fsp_fifo #(
    .Width($bits(fsp_out_t)),
    .Depth(FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_wdata),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_data_o),
    .empty_o(empty)
  );

endmodule
